@@ rtl/product_bounds_propagator_defines.svh @@
// Assertion macros shared by the product bounds propagator RTL.
// Depends on nothing; files that check properties include it by name.
`ifndef PRODUCT_BOUNDS_PROPAGATOR_DEFINES_SVH
`define PRODUCT_BOUNDS_PROPAGATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define PBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define PBP_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define PBP_ASSERT(lbl, prop, msg)
`define PBP_ASSERT_IMPL(lbl, pre, post, msg)
`endif
`endif

@@ rtl/pbp_pkg.sv @@
// Shared types, widths and helper functions of the product bounds propagator.
// Depends on nothing; every RTL module refers to it by scoped names.
package pbp_pkg;
    localparam int BW      = 32;
    localparam int PROD_W  = 2 * BW;
    localparam int QW      = BW + 2;
    localparam int DLY     = BW + 2;

    typedef logic signed [BW-1:0]     t_bound;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [QW-1:0]     t_quot;

    typedef struct packed {
        logic signed [BW-1:0] a_low;
        logic signed [BW-1:0] a_high;
        logic signed [BW-1:0] b_low;
        logic signed [BW-1:0] b_high;
        logic signed [BW-1:0] c_low;
        logic signed [BW-1:0] c_high;
    } t_bounds;

    localparam t_quot QMAX = t_quot'({1'b0, {(BW-1){1'b1}}});
    localparam t_quot QMIN = -QMAX - t_quot'(1);

    function automatic t_bound sat(input t_quot x);
        t_bound res;
        if (x > QMAX) begin
            res = t_bound'(QMAX);
        end else if (x < QMIN) begin
            res = t_bound'(QMIN);
        end else begin
            res = x[BW-1:0];
        end
        return res;
    endfunction

    function automatic t_bound min2(input t_bound x, input t_bound y);
        return (x < y) ? x : y;
    endfunction

    function automatic t_bound max2(input t_bound x, input t_bound y);
        return (x > y) ? x : y;
    endfunction
endpackage

@@ rtl/product_bounds_propagator.sv @@
// Top level of the bounds propagator for the integer constraint a * b = c.
// Depends on pbp_pkg, pbp_div, pbp_mul and the assertion macro header.
//
// Usage: drive the six input bounds and raise start for one cycle; a
// transaction is taken at every rising edge where start is high and busy is
// low. The block is fully pipelined, so busy is never raised and a new
// transaction may be started in every cycle.
// Each transaction yields one result transaction: o_valid is high for exactly
// one cycle with the tightened bounds and the fail flag beside it. The
// accepting edge loads the first of 37 register stages: the eight dividers
// take 34 of them (magnitude stage, one stage per quotient bit, rounding
// stage), the quotient compare takes two while the two-stage product compare
// runs beside it, and the intersection stage takes the last. Throughput is
// one transaction per cycle.
// The receiver cannot stall, so no backpressure exists anywhere inside.
// Reset (synchronous, active low) clears only the valid bits of the pipeline;
// data in flight is dropped and no result appears for it.
`include "product_bounds_propagator_defines.svh"
module product_bounds_propagator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 o_valid,
    input  logic signed [31:0]   i_a_low,
    input  logic signed [31:0]   i_a_high,
    input  logic signed [31:0]   i_b_low,
    input  logic signed [31:0]   i_b_high,
    input  logic signed [31:0]   i_c_low,
    input  logic signed [31:0]   i_c_high,
    output logic signed [31:0]   o_new_a_low,
    output logic signed [31:0]   o_new_a_high,
    output logic signed [31:0]   o_new_b_low,
    output logic signed [31:0]   o_new_b_high,
    output logic signed [31:0]   o_new_c_low,
    output logic signed [31:0]   o_new_c_high,
    output logic                 o_fail
);
    localparam int DLY = pbp_pkg::DLY;

    pbp_pkg::t_bounds w_in;
    assign w_in = '{a_low: i_a_low, a_high: i_a_high, b_low: i_b_low,
                    b_high: i_b_high, c_low: i_c_low, c_high: i_c_high};

    assign busy = 1'b0;

    // Zero divisor endpoints are pushed off zero before the dividers see them.
    pbp_pkg::t_bound w_bl, w_bh, w_al, w_ah;
    assign w_bl = (i_b_low  == '0) ? pbp_pkg::t_bound'(1)  : i_b_low;
    assign w_bh = (i_b_high == '0) ? pbp_pkg::t_bound'(-1) : i_b_high;
    assign w_al = (i_a_low  == '0) ? pbp_pkg::t_bound'(1)  : i_a_low;
    assign w_ah = (i_a_high == '0) ? pbp_pkg::t_bound'(-1) : i_a_high;

    // Quotients for a come from c over b, those for b from c over a.
    pbp_pkg::t_bound w_fl [0:7];
    pbp_pkg::t_bound w_cl [0:7];
    pbp_pkg::t_bound w_num [0:7];
    pbp_pkg::t_bound w_den [0:7];

    assign w_num = '{i_c_low, i_c_high, i_c_low, i_c_high,
                     i_c_low, i_c_high, i_c_low, i_c_high};
    assign w_den = '{w_bl, w_bl, w_bh, w_bh, w_al, w_al, w_ah, w_ah};

    for (genvar g = 0; g < 8; g++) begin : g_div
        pbp_div u_div (
            .i_clk   (i_clk),
            .i_num   (w_num[g]),
            .i_den   (w_den[g]),
            .o_floor (w_fl[g]),
            .o_ceil  (w_cl[g])
        );
    end

    // The raw bounds and the valid bit ride alongside the divider pipeline.
    pbp_pkg::t_bounds r_dly [0:DLY-1];
    logic [DLY-1:0]   r_vld;

    always_ff @(posedge i_clk) begin
        r_dly[0] <= w_in;
        for (int k = 1; k < DLY; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DLY-2:0], start & ~busy};
        end
    end

    pbp_pkg::t_prod w_plo, w_phi;
    pbp_mul u_mul (
        .i_clk (i_clk),
        .i_bnd (r_dly[DLY-1]),
        .o_lo  (w_plo),
        .o_hi  (w_phi)
    );

    // Quotient interval of each factor: least ceiling and greatest floor.
    pbp_pkg::t_bound r_qa_lo, r_qa_hi, r_qb_lo, r_qb_hi;
    pbp_pkg::t_bound r_qa_lo2, r_qa_hi2, r_qb_lo2, r_qb_hi2;
    pbp_pkg::t_bounds r_b2, r_b3;
    logic r_v2, r_v3;

    always_ff @(posedge i_clk) begin
        r_qa_lo  <= pbp_pkg::min2(pbp_pkg::min2(w_cl[0], w_cl[1]),
                                  pbp_pkg::min2(w_cl[2], w_cl[3]));
        r_qa_hi  <= pbp_pkg::max2(pbp_pkg::max2(w_fl[0], w_fl[1]),
                                  pbp_pkg::max2(w_fl[2], w_fl[3]));
        r_qb_lo  <= pbp_pkg::min2(pbp_pkg::min2(w_cl[4], w_cl[5]),
                                  pbp_pkg::min2(w_cl[6], w_cl[7]));
        r_qb_hi  <= pbp_pkg::max2(pbp_pkg::max2(w_fl[4], w_fl[5]),
                                  pbp_pkg::max2(w_fl[6], w_fl[7]));
        r_qa_lo2 <= r_qa_lo;
        r_qa_hi2 <= r_qa_hi;
        r_qb_lo2 <= r_qb_lo;
        r_qb_hi2 <= r_qb_hi;
        r_b2     <= r_dly[DLY-1];
        r_b3     <= r_b2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= r_vld[DLY-1];
            r_v3 <= r_v2;
        end
    end

    // Intersection stage. A factor whose partner interval is [0,0] keeps
    // its bounds, since no quotient exists for it, and its interval is not
    // checked for emptiness.
    logic w_skip_a, w_skip_b, w_fail;
    pbp_pkg::t_bounds w_new;
    pbp_pkg::t_prod   w_ncl, w_nch, w_cl64, w_ch64;

    assign w_skip_a = (r_b3.b_low == '0) && (r_b3.b_high == '0);
    assign w_skip_b = (r_b3.a_low == '0) && (r_b3.a_high == '0);
    assign w_cl64   = pbp_pkg::t_prod'(r_b3.c_low);
    assign w_ch64   = pbp_pkg::t_prod'(r_b3.c_high);
    assign w_ncl    = (w_plo > w_cl64) ? w_plo : w_cl64;
    assign w_nch    = (w_phi < w_ch64) ? w_phi : w_ch64;

    always_comb begin
        w_new.a_low  = w_skip_a ? r_b3.a_low  : pbp_pkg::max2(r_b3.a_low, r_qa_lo2);
        w_new.a_high = w_skip_a ? r_b3.a_high : pbp_pkg::min2(r_b3.a_high, r_qa_hi2);
        w_new.b_low  = w_skip_b ? r_b3.b_low  : pbp_pkg::max2(r_b3.b_low, r_qb_lo2);
        w_new.b_high = w_skip_b ? r_b3.b_high : pbp_pkg::min2(r_b3.b_high, r_qb_hi2);
        w_new.c_low  = w_ncl[pbp_pkg::BW-1:0];
        w_new.c_high = w_nch[pbp_pkg::BW-1:0];
        w_fail = (!w_skip_a && (w_new.a_low > w_new.a_high))
              || (!w_skip_b && (w_new.b_low > w_new.b_high))
              || (w_ncl > w_nch);
    end

    pbp_pkg::t_bounds r_out;
    logic             r_fail, r_vout;

    always_ff @(posedge i_clk) begin
        r_out  <= w_fail ? r_b3 : w_new;
        r_fail <= w_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vout <= 1'b0;
        end else begin
            r_vout <= r_v3;
        end
    end

    assign o_valid      = r_vout;
    assign o_new_a_low  = r_out.a_low;
    assign o_new_a_high = r_out.a_high;
    assign o_new_b_low  = r_out.b_low;
    assign o_new_b_high = r_out.b_high;
    assign o_new_c_low  = r_out.c_low;
    assign o_new_c_high = r_out.c_high;
    assign o_fail       = r_fail;

    // A result without fail holds a nonempty interval for c.
    `PBP_ASSERT_IMPL(a_nonempty, o_valid && !o_fail, o_new_c_low <= o_new_c_high, "successful result holds an empty product interval")
    // Tightening never widens the incoming bounds.
    `PBP_ASSERT(a_tighter, r_v3 && !w_fail |=> (o_new_a_low >= $past(r_b3.a_low)) && (o_new_a_high <= $past(r_b3.a_high)) && (o_new_c_low >= $past(r_b3.c_low)), "tightened bounds lie outside the inputs")
    // On failure all bounds pass through unchanged.
    `PBP_ASSERT(a_passthru, r_v3 && w_fail |=> o_fail && (o_new_b_low == $past(r_b3.b_low)) && (o_new_c_high == $past(r_b3.c_high)), "failed result does not pass the bounds through")
endmodule

@@ rtl/pbp_div.sv @@
// Pipelined signed divider giving floor and ceiling quotients, one bit per stage.
// Depends on pbp_pkg; the divisor must be nonzero.
module pbp_div (
    input  logic            i_clk,
    input  pbp_pkg::t_bound i_num,
    input  pbp_pkg::t_bound i_den,
    output pbp_pkg::t_bound o_floor,
    output pbp_pkg::t_bound o_ceil
);
    localparam int BW = pbp_pkg::BW;

    logic [BW-1:0] r_num [0:BW];
    logic [BW-1:0] r_den [0:BW];
    logic [BW:0]   r_rem [0:BW];
    logic          r_neg [0:BW];
    pbp_pkg::t_bound r_floor, r_ceil;

    // Stage zero takes magnitudes; the quotient sign travels alongside.
    always_ff @(posedge i_clk) begin
        r_num[0] <= i_num[BW-1] ? (BW)'(-i_num) : i_num;
        r_den[0] <= i_den[BW-1] ? (BW)'(-i_den) : i_den;
        r_rem[0] <= '0;
        r_neg[0] <= i_num[BW-1] ^ i_den[BW-1];
    end

    for (genvar k = 0; k < BW; k++) begin : g_step
        logic [BW:0] w_tmp;
        logic        w_ge;
        assign w_tmp = {r_rem[k][BW-1:0], r_num[k][BW-1]};
        assign w_ge  = (w_tmp >= {1'b0, r_den[k]});
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= w_ge ? (w_tmp - {1'b0, r_den[k]}) : w_tmp;
            r_num[k+1] <= {r_num[k][BW-2:0], w_ge};
            r_den[k+1] <= r_den[k];
            r_neg[k+1] <= r_neg[k];
        end
    end

    pbp_pkg::t_quot w_mag, w_trunc, w_floor, w_ceil;
    logic           w_inexact;

    assign w_mag     = pbp_pkg::t_quot'({2'b00, r_num[BW]});
    assign w_trunc   = r_neg[BW] ? -w_mag : w_mag;
    assign w_inexact = |r_rem[BW];
    assign w_floor   = w_trunc - pbp_pkg::t_quot'(r_neg[BW] && w_inexact);
    assign w_ceil    = w_trunc + pbp_pkg::t_quot'(!r_neg[BW] && w_inexact);

    always_ff @(posedge i_clk) begin
        r_floor <= pbp_pkg::sat(w_floor);
        r_ceil  <= pbp_pkg::sat(w_ceil);
    end

    assign o_floor = r_floor;
    assign o_ceil  = r_ceil;
endmodule

@@ rtl/pbp_mul.sv @@
// Corner products of the factor bounds and their least and greatest value.
// Depends on pbp_pkg; two register stages.
module pbp_mul (
    input  logic             i_clk,
    input  pbp_pkg::t_bounds i_bnd,
    output pbp_pkg::t_prod   o_lo,
    output pbp_pkg::t_prod   o_hi
);
    pbp_pkg::t_prod r_p0, r_p1, r_p2, r_p3, r_lo, r_hi;
    pbp_pkg::t_prod w_lo01, w_lo23, w_hi01, w_hi23;

    always_ff @(posedge i_clk) begin
        r_p0 <= pbp_pkg::t_prod'(i_bnd.a_low)  * pbp_pkg::t_prod'(i_bnd.b_low);
        r_p1 <= pbp_pkg::t_prod'(i_bnd.a_high) * pbp_pkg::t_prod'(i_bnd.b_low);
        r_p2 <= pbp_pkg::t_prod'(i_bnd.a_low)  * pbp_pkg::t_prod'(i_bnd.b_high);
        r_p3 <= pbp_pkg::t_prod'(i_bnd.a_high) * pbp_pkg::t_prod'(i_bnd.b_high);
    end

    assign w_lo01 = (r_p1 < r_p0) ? r_p1 : r_p0;
    assign w_lo23 = (r_p3 < r_p2) ? r_p3 : r_p2;
    assign w_hi01 = (r_p1 > r_p0) ? r_p1 : r_p0;
    assign w_hi23 = (r_p3 > r_p2) ? r_p3 : r_p2;

    always_ff @(posedge i_clk) begin
        r_lo <= (w_lo23 < w_lo01) ? w_lo23 : w_lo01;
        r_hi <= (w_hi23 > w_hi01) ? w_hi23 : w_hi01;
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;
endmodule

@@ tb/product_bounds_propagator_tb.sv @@
// Testbench for the product bounds propagator (a * b = c bounds tightening).
// Depends on the RTL top level product_bounds_propagator and its package pbp_pkg.
// Directed corners, then random bounds under several idling phases, all scored
// against an in-bench predictor of the tightened bounds and the fail flag.
module product_bounds_propagator_tb;

    // Bounds of one transaction, as driven on the input ports.
    typedef struct {
        logic signed [31:0] al, ah, bl, bh, cl, ch;
    } bounds_t;

    // Tightened bounds plus the fail flag that the block should return.
    typedef struct {
        logic signed [31:0] al, ah, bl, bh, cl, ch;
        logic               fail;
    } tightened_t;

    localparam longint BOUND_MAX   = 64'sd2147483647;
    localparam longint BOUND_MIN   = -64'sd2147483648;
    localparam int     RESULT_LAT  = 37;
    localparam int     WATCHDOG    = 2000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               o_valid;
    logic signed [31:0] i_a_low = '0, i_a_high = '0, i_b_low = '0;
    logic signed [31:0] i_b_high = '0, i_c_low = '0, i_c_high = '0;
    logic signed [31:0] o_new_a_low, o_new_a_high, o_new_b_low;
    logic signed [31:0] o_new_b_high, o_new_c_low, o_new_c_high;
    logic               o_fail;

    tightened_t expected_bounds[$];
    int  mismatches = 0;
    int  sent_count = 0;
    int  checked_count = 0;
    int  fail_count = 0;
    int  idle_cycles = 0;
    int  send_idle_pct = 0;

    product_bounds_propagator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .o_valid(o_valid),
        .i_a_low(i_a_low), .i_a_high(i_a_high), .i_b_low(i_b_low),
        .i_b_high(i_b_high), .i_c_low(i_c_low), .i_c_high(i_c_high),
        .o_new_a_low(o_new_a_low), .o_new_a_high(o_new_a_high),
        .o_new_b_low(o_new_b_low), .o_new_b_high(o_new_b_high),
        .o_new_c_low(o_new_c_low), .o_new_c_high(o_new_c_high),
        .o_fail(o_fail)
    );

    always #5 i_clk = ~i_clk;

    // Exact floor and ceiling division. Operands stay within 33 signed bits and
    // the divisor is never zero, so 64-bit arithmetic is exact.
    function automatic longint floor_div(longint n, longint d);
        longint q, r;
        q = n / d;
        r = n % d;
        if (r != 0 && ((r < 0) != (d < 0))) q = q - 1;
        return q;
    endfunction

    function automatic longint ceil_div(longint n, longint d);
        longint q, r;
        q = n / d;
        r = n % d;
        if (r != 0 && ((r < 0) == (d < 0))) q = q + 1;
        return q;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > BOUND_MAX) return BOUND_MAX;
        if (x < BOUND_MIN) return BOUND_MIN;
        return x;
    endfunction

    // Interval quotient n / d from the four endpoint quotients only. A zero
    // lower divisor endpoint becomes 1, a zero upper endpoint becomes -1.
    function automatic void quotient_range(input longint nl, nh, dl, dh,
                                           output longint lo, hi);
        longint n[4], d[4], c, f;
        if (dl == 0) dl = 1;
        if (dh == 0) dh = -1;
        n = '{nl, nh, nl, nh};
        d = '{dl, dl, dh, dh};
        lo = clamp32(ceil_div(n[0], d[0]));
        hi = clamp32(floor_div(n[0], d[0]));
        for (int i = 1; i < 4; i++) begin
            c = clamp32(ceil_div(n[i], d[i]));
            f = clamp32(floor_div(n[i], d[i]));
            if (c < lo) lo = c;
            if (f > hi) hi = f;
        end
    endfunction

    function automatic tightened_t tighten_bounds(bounds_t b);
        tightened_t t;
        longint al, ah, bl, bh, cl, ch;
        longint nal, nah, nbl, nbh, ncl, nch, lo, hi;
        longint p[4];
        bit ok;
        al = b.al; ah = b.ah; bl = b.bl; bh = b.bh; cl = b.cl; ch = b.ch;
        nal = al; nah = ah; nbl = bl; nbh = bh; ncl = cl; nch = ch;
        ok = 1'b1;
        // The product of two 32-bit values fits a signed 64-bit longint.
        p = '{al * bl, ah * bl, al * bh, ah * bh};
        lo = p[0];
        hi = p[0];
        for (int i = 1; i < 4; i++) begin
            if (p[i] < lo) lo = p[i];
            if (p[i] > hi) hi = p[i];
        end
        if (lo > ncl) ncl = lo;
        if (hi < nch) nch = hi;
        if (ncl > nch) ok = 1'b0;
        // A divisor interval of exactly [0,0] leaves the other factor alone.
        if (bl != 0 || bh != 0) begin
            quotient_range(cl, ch, bl, bh, lo, hi);
            if (lo > nal) nal = lo;
            if (hi < nah) nah = hi;
            if (nal > nah) ok = 1'b0;
        end
        if (al != 0 || ah != 0) begin
            quotient_range(cl, ch, al, ah, lo, hi);
            if (lo > nbl) nbl = lo;
            if (hi < nbh) nbh = hi;
            if (nbl > nbh) ok = 1'b0;
        end
        // Any empty intersection passes the input bounds through unchanged.
        if (!ok) begin
            nal = al; nah = ah; nbl = bl; nbh = bh; ncl = cl; nch = ch;
        end
        t.al = nal[31:0]; t.ah = nah[31:0]; t.bl = nbl[31:0];
        t.bh = nbh[31:0]; t.cl = ncl[31:0]; t.ch = nch[31:0];
        t.fail = ~ok;
        return t;
    endfunction

    task automatic report_mismatch(input string field, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        mismatches++;
        $display("MISMATCH result %0d field %s: got %0d expected %0d",
                 checked_count, field, got, want);
    endtask

    // Sends one transaction: the bounds and start are raised at a rising edge
    // and held until an edge sees start high with busy low. Start stays high
    // into the next transaction when no idle gap is drawn.
    task automatic send_bounds(input bounds_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_a_low <= b.al; i_a_high <= b.ah; i_b_low <= b.bl;
        i_b_high <= b.bh; i_c_low <= b.cl; i_c_high <= b.ch;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        expected_bounds.push_back(tighten_bounds(b));
        sent_count++;
    endtask

    // Check results at each rising edge; outputs are sampled before the
    // nonblocking updates of this edge land, so ordering is not an issue.
    always @(posedge i_clk) begin
        tightened_t w;
        if (i_rst_n && o_valid) begin
            if (expected_bounds.size() == 0) begin
                // A result strobe with nothing outstanding.
                report_mismatch("o_valid", 32'sd1, 32'sd0);
            end else begin
                w = expected_bounds.pop_front();
                if (o_new_a_low  !== w.al) report_mismatch("new_a_low",  o_new_a_low,  w.al);
                if (o_new_a_high !== w.ah) report_mismatch("new_a_high", o_new_a_high, w.ah);
                if (o_new_b_low  !== w.bl) report_mismatch("new_b_low",  o_new_b_low,  w.bl);
                if (o_new_b_high !== w.bh) report_mismatch("new_b_high", o_new_b_high, w.bh);
                if (o_new_c_low  !== w.cl) report_mismatch("new_c_low",  o_new_c_low,  w.cl);
                if (o_new_c_high !== w.ch) report_mismatch("new_c_high", o_new_c_high, w.ch);
                if (o_fail !== w.fail) report_mismatch("fail", 32'(o_fail), 32'(w.fail));
                if (w.fail) fail_count++;
                checked_count++;
            end
        end
    end

    // Watchdog: counts cycles in which neither side moves a transaction.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG) begin
                $display("watchdog expired after %0d results", checked_count);
                $display("product_bounds_propagator_tb NOT OK");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] rand_bound();
        case ($urandom_range(9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'($signed($urandom_range(6)) - 3);
            3, 4: return 32'($signed($urandom_range(200)) - 100);
            5, 6: return 32'($signed($urandom_range(200000)) - 100000);
            default: return $urandom;
        endcase
    endfunction

    function automatic bounds_t make_bounds(logic signed [31:0] al, ah, bl, bh, cl, ch);
        bounds_t b;
        b.al = al; b.ah = ah; b.bl = bl; b.bh = bh; b.cl = cl; b.ch = ch;
        return b;
    endfunction

    // Mostly well-ordered intervals so the tightening is exercised; a few are
    // inverted or fully random to reach the fail path.
    function automatic bounds_t random_bounds();
        logic signed [31:0] v[6], t;
        bounds_t b;
        for (int i = 0; i < 6; i++) v[i] = rand_bound();
        if ($urandom_range(9) != 0) begin
            for (int i = 0; i < 6; i += 2) begin
                if (v[i] > v[i+1]) begin
                    t = v[i]; v[i] = v[i+1]; v[i+1] = t;
                end
            end
        end
        if ($urandom_range(7) == 0) begin
            v[0] = 0;
            v[1] = 0;
        end
        b = make_bounds(v[0], v[1], v[2], v[3], v[4], v[5]);
        return b;
    endfunction

    task automatic test_directed_corners();
        send_idle_pct = 0;
        send_bounds(make_bounds(2, 5, 3, 4, 0, 100));
        send_bounds(make_bounds(-5, 7, -3, 2, -10, 10));
        send_bounds(make_bounds(0, 0, 0, 0, -1, 1));
        send_bounds(make_bounds(0, 0, 1, 9, 5, 9));       // zero factor, c excludes 0
        send_bounds(make_bounds(1, 9, 0, 0, -3, 3));      // divisor exactly zero
        send_bounds(make_bounds(0, 4, -6, 0, -20, 20));   // zero divisor endpoints
        send_bounds(make_bounds(9, 2, 1, 3, 0, 50));      // inverted interval
        send_bounds(make_bounds(3, 3, 3, 3, 10, 20));     // empty intersection
        send_bounds(make_bounds(-7, -2, -5, -1, 3, 31));
        send_bounds(make_bounds(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                                32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
        send_bounds(make_bounds(32'sh80000000, 32'sh80000000, -1, -1,
                                32'sh80000000, 32'sh7fffffff)); // quotient saturates
        send_bounds(make_bounds(-1, 1, -1, 1, 32'sh80000000, 32'sh7fffffff));
        send_bounds(make_bounds(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                32'sh7fffffff, 0, 32'sh7fffffff));
        send_bounds(make_bounds(32'hffffffff, 32'h7fffffff, 32'h00000001, 32'h55555555,
                                32'haaaaaaaa, 32'h55555555));
        send_bounds(make_bounds(-3, 4, 2, 2, -7, 9));
    endtask

    task automatic test_random_phase(input int idle_pct, input int count);
        send_idle_pct = idle_pct;
        repeat (count) send_bounds(random_bounds());
    endtask

    initial begin
        int drain;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_random_phase(0, 500);
        test_random_phase(75, 350);
        test_random_phase(0, 300);
        test_random_phase(31, 400);
        // Drop start before the next edge so the last transaction is not taken twice.
        start <= 1'b0;
        drain = 0;
        while (expected_bounds.size() != 0 && drain < 10 * RESULT_LAT) begin
            @(posedge i_clk);
            drain++;
        end
        // Keep clocking in case a stray result follows the last one.
        repeat (RESULT_LAT) @(posedge i_clk);
        $display("Sent %0d bound sets, checked %0d results, %0d with fail raised.",
                 sent_count, checked_count, fail_count);
        $display("Phases covered back-to-back starts and 75%% and 31%% sender idling.");
        if (mismatches == 0 && expected_bounds.size() == 0) begin
            $display("product_bounds_propagator_tb OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_bounds.size());
            $display("product_bounds_propagator_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pbp_pkg.sv
rtl/pbp_div.sv
rtl/pbp_mul.sv
rtl/product_bounds_propagator.sv
tb/product_bounds_propagator_tb.sv
